FILE: hw/rtl/owbm_pkg.sv
// Shared types and constants for the 1-Wire bus master.
// No dependencies; the top unit, owbm_cfg_regs and owbm_core use this package.
package owbm_pkg;

    localparam int TIMER_WIDTH_DEF = 10;
    localparam int CFG_DATA_W      = 10;
    localparam int CFG_INDEX_W     = 3;

    // item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_BYTE  = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_PULSE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRES_TMO    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_LOW    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT        = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RECOVERY    = 3'd6;

    // register reset values
    localparam logic [9:0] RESET_PULSE_DEF = 10'd500;
    localparam logic [7:0] SETTLE_DEF      = 8'd10;
    localparam logic [9:0] PRES_TMO_DEF    = 10'd250;
    localparam logic [3:0] SLOT_LOW_DEF    = 4'd1;
    localparam logic [5:0] SAMPLE_PT_DEF   = 6'd14;
    localparam logic [7:0] SLOT_DEF        = 8'd60;
    localparam logic [7:0] RECOVERY_DEF    = 8'd1;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_RST_LOW   = 3'd1,
        PH_SETTLE    = 3'd2,
        PH_WAIT_LOW  = 3'd3,
        PH_WAIT_HIGH = 3'd4,
        PH_SLOT      = 3'd5,
        PH_RECOVER   = 3'd6
    } phase_t;

    typedef struct packed {
        logic [9:0] reset_pulse_us;
        logic [7:0] settle_us;
        logic [9:0] presence_timeout_us;
        logic [3:0] slot_low_us;
        logic [5:0] sample_point_us;
        logic [7:0] slot_us;
        logic [7:0] recovery_us;
    } cfg_t;

endpackage

FILE: hw/rtl/owbm_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on nothing.
interface owbm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       line_level;

    modport source (output valid, kind, tx_byte, line_level, input ready);
    modport sink   (input valid, kind, tx_byte, line_level, output ready);
endinterface

interface owbm_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;

    modport source (output valid, drive_low, busy_res, done_res, presence, rx_byte,
                    input ready);
    modport sink   (input valid, drive_low, busy_res, done_res, presence, rx_byte,
                    output ready);
endinterface

FILE: hw/rtl/one_wire_bus_master_unit.sv
// 1-Wire bus master. One item is taken per clock while the result register can
// accept it: command items start a reset or byte exchange, tick items advance
// bus timing by one microsecond. Each item gives one result item in the next cycle,
// out of a single result register; the input stays ready while that register is
// empty or being taken, so the rate is one item per cycle unless results are held.
// Depends on owbm_pkg, owbm_if, owbm_cfg_regs and owbm_core.
module one_wire_bus_master_unit #(
    parameter int TIMER_WIDTH = owbm_pkg::TIMER_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    owbm_in_if.sink                             cmd,
    owbm_out_if.source                          res,
    input  logic                                write_en,
    input  logic [owbm_pkg::CFG_INDEX_W-1:0]    reg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]     write_data
);

    owbm_pkg::cfg_t cfg;
    logic           in_fire;
    logic           idle;

    assign cmd.ready = !res.valid || res.ready;
    assign in_fire   = cmd.valid && cmd.ready;

    owbm_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .write_en   (write_en),
        .reg_index  (reg_index),
        .write_data (write_data),
        .cfg        (cfg)
    );

    owbm_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .kind       (cmd.kind),
        .tx_byte    (cmd.tx_byte),
        .line_level (cmd.line_level),
        .cfg        (cfg),
        .res_ready  (res.ready),
        .res_valid  (res.valid),
        .drive_low  (res.drive_low),
        .busy_res   (res.busy_res),
        .done_res   (res.done_res),
        .presence   (res.presence),
        .rx_byte    (res.rx_byte),
        .idle       (idle)
    );

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> res.valid)
        else $error("accepted item produced no result");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.done_res) |-> (!res.busy_res && idle))
        else $error("completion reported while still busy");

    a_drive_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.drive_low) |-> res.busy_res)
        else $error("line driven low while idle");

    a_busy_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (res.busy_res == !idle))
        else $error("busy flag disagrees with phase");

endmodule

FILE: hw/rtl/owbm_cfg_regs.sv
// Timing configuration registers of the 1-Wire master.
// Depends on owbm_pkg.
module owbm_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                write_en,
    input  logic [owbm_pkg::CFG_INDEX_W-1:0]    reg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]     write_data,
    output owbm_pkg::cfg_t                      cfg
);

    owbm_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_pulse_us      <= owbm_pkg::RESET_PULSE_DEF;
            cfg_reg.settle_us           <= owbm_pkg::SETTLE_DEF;
            cfg_reg.presence_timeout_us <= owbm_pkg::PRES_TMO_DEF;
            cfg_reg.slot_low_us         <= owbm_pkg::SLOT_LOW_DEF;
            cfg_reg.sample_point_us     <= owbm_pkg::SAMPLE_PT_DEF;
            cfg_reg.slot_us             <= owbm_pkg::SLOT_DEF;
            cfg_reg.recovery_us         <= owbm_pkg::RECOVERY_DEF;
        end
        else if (write_en)
        begin
            case (reg_index)
                owbm_pkg::REG_RESET_PULSE: cfg_reg.reset_pulse_us      <= write_data[9:0];
                owbm_pkg::REG_SETTLE:      cfg_reg.settle_us           <= write_data[7:0];
                owbm_pkg::REG_PRES_TMO:    cfg_reg.presence_timeout_us <= write_data[9:0];
                owbm_pkg::REG_SLOT_LOW:    cfg_reg.slot_low_us         <= write_data[3:0];
                owbm_pkg::REG_SAMPLE_PT:   cfg_reg.sample_point_us     <= write_data[5:0];
                owbm_pkg::REG_SLOT:        cfg_reg.slot_us             <= write_data[7:0];
                owbm_pkg::REG_RECOVERY:    cfg_reg.recovery_us         <= write_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/owbm_core.sv
// Bus phase sequencer and result register of the 1-Wire master.
// Depends on owbm_pkg.
module owbm_core #(
    parameter int TIMER_WIDTH = owbm_pkg::TIMER_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic [1:0]      kind,
    input  logic [7:0]      tx_byte,
    input  logic            line_level,
    input  owbm_pkg::cfg_t  cfg,
    input  logic            res_ready,
    output logic            res_valid,
    output logic            drive_low,
    output logic            busy_res,
    output logic            done_res,
    output logic            presence,
    output logic [7:0]      rx_byte,
    output logic            idle
);

    localparam int TW = TIMER_WIDTH;
    localparam int CW = (TW > owbm_pkg::CFG_DATA_W) ? TW : owbm_pkg::CFG_DATA_W;
    localparam logic [TW-1:0] TMAX_T = {TW{1'b1}};
    localparam logic [CW-1:0] TMAX   = CW'(TMAX_T);

    function automatic logic [CW-1:0] lim(input logic [CW-1:0] v);
        return (v > TMAX) ? TMAX : v;
    endfunction

    owbm_pkg::phase_t phase_reg, phase_next;
    logic [TW-1:0] tick_reg, tick_next, tick_inc;
    logic [7:0]    shift_reg, shift_next;
    logic [2:0]    bit_reg, bit_next;
    logic          pres_reg, pres_next;
    logic          txbit_reg, txbit_next;

    logic          valid_reg;
    logic          drive_reg, busy_reg, done_reg;
    logic          drive_c, busy_c, done_c;

    logic [CW-1:0] tick_inc_w;
    logic [CW-1:0] lim_reset, lim_settle, lim_tmo, lim_recov;
    logic [CW-1:0] eff_slot, eff_sample, eff_low, sample_raw;

    assign tick_inc   = (tick_reg < TMAX_T) ? tick_reg + 1'b1 : tick_reg;
    assign tick_inc_w = CW'(tick_inc);

    assign lim_reset  = lim(CW'(cfg.reset_pulse_us));
    assign lim_settle = lim(CW'(cfg.settle_us));
    assign lim_tmo    = lim(CW'(cfg.presence_timeout_us));
    assign lim_recov  = lim(CW'(cfg.recovery_us));
    assign eff_slot   = lim((cfg.slot_us == 8'd0) ? CW'(1) : CW'(cfg.slot_us));
    assign sample_raw = (cfg.sample_point_us == 6'd0) ? CW'(1) : CW'(cfg.sample_point_us);
    assign eff_sample = (sample_raw > eff_slot) ? eff_slot : sample_raw;
    assign eff_low    = (cfg.slot_low_us == 4'd0) ? CW'(1) : CW'(cfg.slot_low_us);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        bit_next   = bit_reg;
        pres_next  = pres_reg;
        txbit_next = txbit_reg;
        if (in_fire)
        begin
            case (kind)
                owbm_pkg::KIND_RESET:
                begin
                    if (phase_reg == owbm_pkg::PH_IDLE)
                    begin
                        phase_next = owbm_pkg::PH_RST_LOW;
                        tick_next  = '0;
                    end
                end
                owbm_pkg::KIND_BYTE:
                begin
                    if (phase_reg == owbm_pkg::PH_IDLE)
                    begin
                        shift_next = tx_byte;
                        bit_next   = 3'd0;
                        phase_next = owbm_pkg::PH_SLOT;
                        tick_next  = '0;
                        txbit_next = tx_byte[0];
                    end
                end
                owbm_pkg::KIND_TICK:
                begin
                    case (phase_reg)
                        owbm_pkg::PH_RST_LOW:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc_w >= lim_reset)
                            begin
                                tick_next  = '0;
                                phase_next = (cfg.settle_us == 8'd0) ?
                                             owbm_pkg::PH_WAIT_LOW : owbm_pkg::PH_SETTLE;
                            end
                        end
                        owbm_pkg::PH_SETTLE:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc_w >= lim_settle)
                            begin
                                tick_next  = '0;
                                phase_next = owbm_pkg::PH_WAIT_LOW;
                            end
                        end
                        owbm_pkg::PH_WAIT_LOW:
                        begin
                            if (!line_level)
                            begin
                                tick_next  = '0;
                                phase_next = owbm_pkg::PH_WAIT_HIGH;
                            end
                            else if (tick_inc_w >= lim_tmo)
                            begin
                                pres_next  = 1'b0;
                                phase_next = owbm_pkg::PH_IDLE;
                                tick_next  = '0;
                            end
                            else
                                tick_next = tick_inc;
                        end
                        owbm_pkg::PH_WAIT_HIGH:
                        begin
                            if (line_level)
                            begin
                                pres_next  = 1'b1;
                                phase_next = owbm_pkg::PH_IDLE;
                                tick_next  = '0;
                            end
                            else if (tick_inc_w >= lim_tmo)
                            begin
                                pres_next  = 1'b0;
                                phase_next = owbm_pkg::PH_IDLE;
                                tick_next  = '0;
                            end
                            else
                                tick_next = tick_inc;
                        end
                        owbm_pkg::PH_SLOT:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc_w == eff_sample)
                                shift_next = {line_level, shift_reg[7:1]};
                            if (tick_inc_w >= eff_slot)
                            begin
                                tick_next  = '0;
                                phase_next = owbm_pkg::PH_RECOVER;
                            end
                        end
                        owbm_pkg::PH_RECOVER:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc_w >= lim_recov)
                            begin
                                tick_next = '0;
                                if (bit_reg == 3'd7)
                                begin
                                    bit_next   = 3'd0;
                                    phase_next = owbm_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    bit_next   = bit_reg + 3'd1;
                                    phase_next = owbm_pkg::PH_SLOT;
                                    txbit_next = shift_reg[0];
                                end
                            end
                        end
                        default: phase_next = owbm_pkg::PH_IDLE;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // result fields
    always_comb
    begin
        drive_c = 1'b0;
        case (phase_next)
            owbm_pkg::PH_RST_LOW: drive_c = 1'b1;
            owbm_pkg::PH_SLOT:    drive_c = !txbit_next || (CW'(tick_next) < eff_low);
            default:              drive_c = 1'b0;
        endcase
        busy_c = (phase_next != owbm_pkg::PH_IDLE);
        // only the two presence-wait phases and the recovery phase can end an operation on a tick
        done_c = in_fire && (kind == owbm_pkg::KIND_TICK)
                 && (phase_next == owbm_pkg::PH_IDLE)
                 && (phase_reg == owbm_pkg::PH_WAIT_LOW
                     || phase_reg == owbm_pkg::PH_WAIT_HIGH
                     || phase_reg == owbm_pkg::PH_RECOVER);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= owbm_pkg::PH_IDLE;
            tick_reg  <= '0;
            shift_reg <= '0;
            bit_reg   <= '0;
            pres_reg  <= 1'b0;
            txbit_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            bit_reg   <= bit_next;
            pres_reg  <= pres_next;
            txbit_reg <= txbit_next;
            if (in_fire)
                valid_reg <= 1'b1;
            else if (res_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            drive_reg <= drive_c;
            busy_reg  <= busy_c;
            done_reg  <= done_c;
        end
    end

    assign res_valid = valid_reg;
    assign drive_low = drive_reg;
    assign busy_res  = busy_reg;
    assign done_res  = done_reg;
    // presence and shift register hold until the next accepted item
    assign presence  = pres_reg;
    assign rx_byte   = shift_reg;
    assign idle      = (phase_reg == owbm_pkg::PH_IDLE);

endmodule
